### hw/rtl/ppc_pkg.sv
// Shared types, register codes and helpers for the point-plane classifier.
package ppc_pkg;

	// Register indexes on the configuration port, one word apart.
	typedef enum logic [2:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_OFFSET   = 3'd3,
		REG_EPSILON  = 3'd4
	} reg_idx_t;

	// Side codes on the result.
	localparam logic [1:0] SIDE_FRONT  = 2'd0;
	localparam logic [1:0] SIDE_BEHIND = 2'd1;
	localparam logic [1:0] SIDE_ON     = 2'd2;

	// Reset values of the plane registers (normal points along +z, 1.0 in Q16.16).
	localparam logic signed [17:0] NORMAL_X_RST = 18'sd0;
	localparam logic signed [17:0] NORMAL_Y_RST = 18'sd0;
	localparam logic signed [17:0] NORMAL_Z_RST = 18'sd65536;
	localparam logic signed [31:0] OFFSET_RST   = 32'sd0;
	localparam logic [15:0]        EPSILON_RST  = 16'd1;

	// Plane configuration as seen by the datapath.
	typedef struct packed {
		logic signed [17:0] normal_x;
		logic signed [17:0] normal_y;
		logic signed [17:0] normal_z;
		logic signed [31:0] plane_offset;
		logic [15:0]        epsilon;
	} cfg_t;

	// Distance stage result handed to the projection stages.
	typedef struct packed {
		logic signed [31:0] distance;
		logic [1:0]         side;
		logic               on_plane;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic signed [31:0] qz;
	} dist_res_t;

	// Saturate a sign-extended value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic fits;
		fits = (v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}});
		if (fits) begin
			sat32 = v[31:0];
		end else if (v[63]) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = 32'sh7fff_ffff;
		end
	endfunction

endpackage

### hw/rtl/ppc_cfg.sv
// APB register file holding the plane normal, offset and band half width.
module ppc_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output ppc_pkg::cfg_t      cfg
);

	ppc_pkg::cfg_t    cfg_q;
	ppc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = ppc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; addresses past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x     <= ppc_pkg::NORMAL_X_RST;
			cfg_q.normal_y     <= ppc_pkg::NORMAL_Y_RST;
			cfg_q.normal_z     <= ppc_pkg::NORMAL_Z_RST;
			cfg_q.plane_offset <= ppc_pkg::OFFSET_RST;
			cfg_q.epsilon      <= ppc_pkg::EPSILON_RST;
		end else if (wr_en) begin
			unique case (idx)
				ppc_pkg::REG_NORMAL_X: cfg_q.normal_x     <= pwdata[17:0];
				ppc_pkg::REG_NORMAL_Y: cfg_q.normal_y     <= pwdata[17:0];
				ppc_pkg::REG_NORMAL_Z: cfg_q.normal_z     <= pwdata[17:0];
				ppc_pkg::REG_OFFSET:   cfg_q.plane_offset <= pwdata;
				ppc_pkg::REG_EPSILON:  cfg_q.epsilon      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux; signed registers read back sign extended.
	always_comb begin
		unique case (idx)
			ppc_pkg::REG_NORMAL_X: prdata = {{14{cfg_q.normal_x[17]}}, cfg_q.normal_x};
			ppc_pkg::REG_NORMAL_Y: prdata = {{14{cfg_q.normal_y[17]}}, cfg_q.normal_y};
			ppc_pkg::REG_NORMAL_Z: prdata = {{14{cfg_q.normal_z[17]}}, cfg_q.normal_z};
			ppc_pkg::REG_OFFSET:   prdata = cfg_q.plane_offset;
			ppc_pkg::REG_EPSILON:  prdata = {16'd0, cfg_q.epsilon};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

### hw/rtl/ppc_dist.sv
// Four-stage signed distance pipeline: products, sum, offset subtract, classify.
module ppc_dist #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppc_pkg::cfg_t        cfg,
	input  logic                 point_valid,
	output logic                 point_stall,
	input  logic signed [31:0]   point_x,
	input  logic signed [31:0]   point_y,
	input  logic signed [31:0]   point_z,
	output logic                 res_valid,
	input  logic                 res_take,
	output ppc_pkg::dist_res_t   res
);

	localparam int PROD_W = 50;
	localparam int SUM_W  = 52;
	localparam int DOT_W  = SUM_W - FRAC_BITS;
	localparam int DIST_W = ((DOT_W > 32) ? DOT_W : 32) + 1;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [31:0]       qx_s1, qy_s1, qz_s1;
	logic signed [SUM_W-1:0]  sum_s2;
	logic signed [31:0]       qx_s2, qy_s2, qz_s2;
	logic signed [DIST_W-1:0] dist_s3;
	logic signed [31:0]       qx_s3, qy_s3, qz_s3;
	ppc_pkg::dist_res_t       res_s4;

	logic signed [SUM_W-1:0]  sum_c;
	logic signed [DOT_W-1:0]  dot_c;
	logic signed [DIST_W-1:0] dist_c;
	logic signed [DIST_W-1:0] eps_pos, eps_neg;
	logic [1:0]               side_c;

	// A stage loads when it is empty or its contents move on.
	assign en_s4       = !v_s4 || res_take;
	assign en_s3       = !v_s3 || en_s4;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign point_stall = !en_s1;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= point_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: one 18 by 32 multiply per axis.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			px_s1 <= cfg.normal_x * point_x;
			py_s1 <= cfg.normal_y * point_y;
			pz_s1 <= cfg.normal_z * point_z;
			qx_s1 <= point_x;
			qy_s1 <= point_y;
			qz_s1 <= point_z;
		end
	end

	// Stage 2: exact dot product plus the rounding half.
	assign sum_c = {{(SUM_W-PROD_W){px_s1[PROD_W-1]}}, px_s1}
	             + {{(SUM_W-PROD_W){py_s1[PROD_W-1]}}, py_s1}
	             + {{(SUM_W-PROD_W){pz_s1[PROD_W-1]}}, pz_s1}
	             + HALF;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sum_s2 <= sum_c;
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			qz_s2  <= qz_s1;
		end
	end

	// Stage 3: drop the extra fraction bits and subtract the plane offset.
	assign dot_c  = sum_s2[SUM_W-1:FRAC_BITS];
	assign dist_c = {{(DIST_W-DOT_W){dot_c[DOT_W-1]}}, dot_c}
	              - {{(DIST_W-32){cfg.plane_offset[31]}}, cfg.plane_offset};

	always_ff @(posedge clk) begin
		if (en_s3) begin
			dist_s3 <= dist_c;
			qx_s3   <= qx_s2;
			qy_s3   <= qy_s2;
			qz_s3   <= qz_s2;
		end
	end

	// Stage 4: classify on the full distance, then saturate it.
	assign eps_pos = {{(DIST_W-16){1'b0}}, cfg.epsilon};
	assign eps_neg = -eps_pos;

	always_comb begin
		if (dist_s3 > eps_pos) begin
			side_c = ppc_pkg::SIDE_FRONT;
		end else if (dist_s3 < eps_neg) begin
			side_c = ppc_pkg::SIDE_BEHIND;
		end else begin
			side_c = ppc_pkg::SIDE_ON;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			res_s4.distance <= ppc_pkg::sat32({{(64-DIST_W){dist_s3[DIST_W-1]}}, dist_s3});
			res_s4.side     <= side_c;
			res_s4.on_plane <= (side_c == ppc_pkg::SIDE_ON);
			res_s4.qx       <= qx_s3;
			res_s4.qy       <= qy_s3;
			res_s4.qz       <= qz_s3;
		end
	end

	assign res_valid = v_s4;
	assign res       = res_s4;

	// A point classed in front or behind always has a nonzero distance of that sign.
	a_front_pos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (res_s4.side == ppc_pkg::SIDE_FRONT) |-> res_s4.distance > 32'sd0)
		else $error("front point with non-positive distance");

	a_behind_neg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (res_s4.side == ppc_pkg::SIDE_BEHIND) |-> res_s4.distance < 32'sd0)
		else $error("behind point with non-negative distance");

	// A full stage that moves on always lands in the next stage.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en_s2 |=> v_s2)
		else $error("request lost between stage 1 and stage 2");

	// A result held by the projection side keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !res_take |=> v_s4 && $stable(res_s4))
		else $error("held distance result changed");

endmodule

### hw/rtl/ppc_proj.sv
// Two-stage projection pipeline: distance times normal, then round, subtract, saturate.
module ppc_proj #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppc_pkg::cfg_t        cfg,
	input  logic                 res_valid,
	output logic                 res_take,
	input  ppc_pkg::dist_res_t   res,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic signed [31:0]   signed_distance,
	output logic [1:0]           side,
	output logic                 on_plane,
	output logic signed [31:0]   projected_x,
	output logic signed [31:0]   projected_y,
	output logic signed [31:0]   projected_z
);

	localparam int PROD_W = 50;
	localparam int RND_W  = PROD_W + 1;
	localparam int SH_W   = RND_W - FRAC_BITS;
	localparam int DIFF_W = ((SH_W > 32) ? SH_W : 32) + 1;
	localparam logic signed [RND_W-1:0] HALF = RND_W'(1) << (FRAC_BITS - 1);

	logic v_s5, v_s6;
	logic en_s5, en_s6;

	ppc_pkg::dist_res_t       res_s5;
	logic signed [PROD_W-1:0] mx_s5, my_s5, mz_s5;
	logic signed [31:0]       dist_s6, px_s6, py_s6, pz_s6;
	logic [1:0]               side_s6;
	logic                     on_s6;

	logic signed [31:0] proj_x_c, proj_y_c, proj_z_c;

	// Round a distance-normal product and take it from the coordinate.
	function automatic logic signed [31:0] proj_axis(input logic signed [31:0] q,
		input logic signed [PROD_W-1:0] m);
		logic signed [RND_W-1:0]  r;
		logic signed [SH_W-1:0]   s;
		logic signed [DIFF_W-1:0] d;
		r = {m[PROD_W-1], m} + HALF;
		s = r[RND_W-1:FRAC_BITS];
		d = {{(DIFF_W-32){q[31]}}, q} - {{(DIFF_W-SH_W){s[SH_W-1]}}, s};
		proj_axis = ppc_pkg::sat32({{(64-DIFF_W){d[DIFF_W-1]}}, d});
	endfunction

	// The output register frees when the receiver takes the request.
	assign en_s6    = !v_s6 || !result_stall;
	assign en_s5    = !v_s5 || en_s6;
	assign res_take = en_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= res_valid;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 5: saturated distance times each normal component.
	always_ff @(posedge clk) begin
		if (en_s5) begin
			res_s5 <= res;
			mx_s5  <= res.distance * cfg.normal_x;
			my_s5  <= res.distance * cfg.normal_y;
			mz_s5  <= res.distance * cfg.normal_z;
		end
	end

	assign proj_x_c = proj_axis(res_s5.qx, mx_s5);
	assign proj_y_c = proj_axis(res_s5.qy, my_s5);
	assign proj_z_c = proj_axis(res_s5.qz, mz_s5);

	// Stage 6: output register.
	always_ff @(posedge clk) begin
		if (en_s6) begin
			dist_s6 <= res_s5.distance;
			side_s6 <= res_s5.side;
			on_s6   <= res_s5.on_plane;
			px_s6   <= proj_x_c;
			py_s6   <= proj_y_c;
			pz_s6   <= proj_z_c;
		end
	end

	assign result_valid    = v_s6;
	assign signed_distance = dist_s6;
	assign side            = side_s6;
	assign on_plane        = on_s6;
	assign projected_x     = px_s6;
	assign projected_y     = py_s6;
	assign projected_z     = pz_s6;

	// The on-plane flag and the side code always agree.
	a_on_side: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (on_s6 == (side_s6 == ppc_pkg::SIDE_ON)))
		else $error("on_plane disagrees with side");

	// A zero distance leaves every coordinate where it was.
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && en_s6 && (res_s5.distance == 32'sd0) |=>
		(px_s6 == $past(res_s5.qx)) && (py_s6 == $past(res_s5.qy))
		&& (pz_s6 == $past(res_s5.qz)))
		else $error("projection moved a point lying on the plane");

	// A request entering the last stage is shown on the next cycle.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && en_s6 |=> v_s6)
		else $error("request lost before the output register");

endmodule

### hw/rtl/point_plane_classify_project_top.sv
// Top level of the point-plane distance, side and projection pipeline.
//
// Points arrive on the point channel (point_valid, point_stall, point_x/y/z)
// and one result per point leaves on the result channel (result_valid,
// result_stall, signed_distance, side, on_plane, projected_x/y/z), in order.
// The plane is set through the APB port: normal_x, normal_y, normal_z,
// plane_offset and epsilon at byte addresses 0, 4, 8, 12 and 16; write it only
// while no point is in flight. pready is always high.
// The pipeline takes one point per cycle while point_stall is low. Its six
// stages: one 18 by 32 multiply per axis, the wide sum, the offset subtract,
// the classify, the distance-normal multiplies, the round-subtract-saturate.
// Reset empties the pipeline and loads a plane through the origin with its
// normal along +z and a band half width of one LSB. When the receiver stalls,
// the output register holds its request and stages behind it keep filling
// until the pipeline is full; only then is point_stall raised.
module point_plane_classify_project_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               point_valid,
	output logic               point_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] signed_distance,
	output logic [1:0]         side,
	output logic               on_plane,
	output logic signed [31:0] projected_x,
	output logic signed [31:0] projected_y,
	output logic signed [31:0] projected_z
);

	ppc_pkg::cfg_t      cfg;
	ppc_pkg::dist_res_t dres;
	logic               dres_valid;
	logic               dres_take;

	// Plane registers.
	ppc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Distance and classification stages.
	ppc_dist #(
		.FRAC_BITS (FRAC_BITS)
	) u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.res_valid   (dres_valid),
		.res_take    (dres_take),
		.res         (dres)
	);

	// Projection stages and output register.
	ppc_proj #(
		.FRAC_BITS (FRAC_BITS)
	) u_proj (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.res_valid       (dres_valid),
		.res_take        (dres_take),
		.res             (dres),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.signed_distance (signed_distance),
		.side            (side),
		.on_plane        (on_plane),
		.projected_x     (projected_x),
		.projected_y     (projected_y),
		.projected_z     (projected_z)
	);

endmodule
